FILE: rtl/yaz0_pkg.sv
// yaz0_pkg: shared types and constants for the yaz0 stream decompressor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package yaz0_pkg;

	localparam int HEADER_BYTES = 16;

	localparam logic [2:0] ST_RUN       = 3'd0;
	localparam logic [2:0] ST_OK        = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
	localparam logic [2:0] ST_DIST      = 3'd3;
	localparam logic [2:0] ST_TRUNC     = 3'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_bytes;
		logic [3:0]  out_count;
		logic        out_last;
		logic [2:0]  out_status;
	} out_item_t;

	// command from the parser to the copy engine
	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_COPY,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  lit;
		logic [11:0] offset;
		logic [8:0]  len;
		logic [2:0]  status;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_WAIT
	} back_state_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		unique case (idx)
			2'd0: m = 8'h59;
			2'd1: m = 8'h61;
			2'd2: m = 8'h7A;
			default: m = 8'h30;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/yaz0_ram.sv
// yaz0_ram: generic single write, single read RAM with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module yaz0_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/yaz0_cmd_fifo.sv
// yaz0_cmd_fifo: two-entry queue of commands between parser and copy engine
// depends on yaz0_pkg
`timescale 1ns / 1ps
`default_nettype none
module yaz0_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr,
	input  wire yaz0_pkg::cmd_t wdata,
	output logic                full,
	input  wire logic           rd,
	output yaz0_pkg::cmd_t      rdata,
	output logic                empty
);
	yaz0_pkg::cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr && !full} - {1'b0, rd && !empty};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("command queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		full && !rd |=> full)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		empty && !wr |=> empty)
		else $error("empty queue gained an entry");
endmodule
`default_nettype wire

FILE: rtl/yaz0_parser.sv
// yaz0_parser: header check, group codes and token decode, one byte a cycle while the command queue has room
// depends on yaz0_pkg
`timescale 1ns / 1ps
`default_nettype none
module yaz0_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire yaz0_pkg::in_item_t in_item,
	output logic                    full,
	output logic                    cmd_wr,
	output yaz0_pkg::cmd_t          cmd,
	input  wire logic               cmd_full,
	input  wire logic               done
);
	logic [4:0]  hdr_q;
	logic [31:0] target_q;
	logic [7:0]  code_q;
	logic [3:0]  left_q;
	logic [1:0]  phase_q;
	logic [7:0]  first_q, second_q;
	logic        fin_q;
	// count of produced bytes as the parser sees it, for distance and end checks
	logic [31:0] prod_q;

	logic        acc;
	logic [7:0]  b;
	logic [2:0]  status;
	logic [4:0]  hdr_n;
	logic [31:0] target_n;
	logic [31:0] prod_n;
	logic [11:0] offset;
	logic [8:0]  len;
	logic [31:0] room;
	logic [31:0] eff;
	logic        do_lit, do_copy;

	// parser stops taking input once the stream ends, until reset
	assign full = fin_q || cmd_full;
	assign acc  = push && !full;
	assign b    = in_item.in_byte;

	always_comb begin
		status   = yaz0_pkg::ST_RUN;
		hdr_n    = hdr_q;
		target_n = target_q;
		do_lit   = 1'b0;
		do_copy  = 1'b0;
		offset   = 12'd0;
		len      = 9'd0;
		if (hdr_q < 5'(yaz0_pkg::HEADER_BYTES)) begin
			if (hdr_q < 5'd4) begin
				if (b != yaz0_pkg::magic_byte(hdr_q[1:0])) status = yaz0_pkg::ST_BAD_MAGIC;
			end else if (hdr_q < 5'd8) begin
				target_n = {target_q[23:0], b};
			end
			if (status == yaz0_pkg::ST_RUN) begin
				hdr_n = hdr_q + 5'd1;
				if (hdr_n == 5'(yaz0_pkg::HEADER_BYTES) && target_n == 32'd0)
					status = yaz0_pkg::ST_OK;
			end
		end else if (phase_q == 2'd0 && left_q != 4'd0 && code_q[7]) begin
			do_lit = 1'b1;
		end else if (phase_q == 2'd1 && first_q[7:4] != 4'd0) begin
			do_copy = 1'b1;
			offset = {first_q[3:0], b};
			len  = {5'd0, first_q[7:4]} + 9'd2;
		end else if (phase_q == 2'd2) begin
			do_copy = 1'b1;
			offset = {first_q[3:0], second_q};
			len  = {1'b0, b} + 9'h12;
		end
		room = target_q - prod_q;
		eff  = do_lit ? 32'd1 : (room < {23'd0, len} ? room : {23'd0, len});
		if (do_copy && ({20'd0, offset} + 32'd1 > prod_q)) begin
			status  = yaz0_pkg::ST_DIST;
			do_copy = 1'b0;
		end
		prod_n = (do_lit || do_copy) ? prod_q + eff : prod_q;
		if (status == yaz0_pkg::ST_RUN && hdr_n >= 5'(yaz0_pkg::HEADER_BYTES)
			&& hdr_q >= 5'(yaz0_pkg::HEADER_BYTES) && prod_n >= target_q)
			status = yaz0_pkg::ST_OK;
		if (status == yaz0_pkg::ST_RUN && in_item.in_last) status = yaz0_pkg::ST_TRUNC;
	end

	always_comb begin
		cmd.kind   = do_lit ? yaz0_pkg::CMD_LIT : (do_copy ? yaz0_pkg::CMD_COPY : yaz0_pkg::CMD_END);
		cmd.lit    = b;
		cmd.offset = offset;
		cmd.len    = eff[8:0];
		cmd.status = status;
		cmd_wr     = acc && (do_lit || do_copy || status != yaz0_pkg::ST_RUN);
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (phase_q == 2'd0) first_q <= b;
			if (phase_q == 2'd1) second_q <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0; target_q <= '0; code_q <= '0; left_q <= '0;
			phase_q <= '0; fin_q <= 1'b0; prod_q <= '0;
		end else if (acc) begin
			hdr_q <= hdr_n;
			target_q <= target_n;
			prod_q <= prod_n;
			if (status != yaz0_pkg::ST_RUN) fin_q <= 1'b1;
			if (hdr_q >= 5'(yaz0_pkg::HEADER_BYTES)) begin
				if (phase_q == 2'd0 && left_q == 4'd0) begin
					code_q <= b;
					left_q <= 4'd8;
				end else if (phase_q == 2'd0 && !code_q[7]) begin
					phase_q <= 2'd1;
				end else if (phase_q == 2'd1 && first_q[7:4] == 4'd0) begin
					phase_q <= 2'd2;
				end else begin
					code_q <= {code_q[6:0], 1'b0};
					left_q <= left_q - 4'd1;
					phase_q <= 2'd0;
				end
			end
		end
		else if (done) begin
			// stream end delivered: stay finished
			fin_q <= 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) fin_q |=> fin_q)
		else $error("parser left finished state");
	assert property (@(posedge clk) disable iff (!arst_n) phase_q != 2'd3)
		else $error("bad token phase");
	assert property (@(posedge clk) disable iff (!arst_n) cmd_wr |-> !cmd_full)
		else $error("command written into full queue");
endmodule
`default_nettype wire

FILE: rtl/yaz0_copier.sv
// yaz0_copier: executes literal and copy commands against the history RAM and packs output
// depends on yaz0_pkg, yaz0_ram
`timescale 1ns / 1ps
`default_nettype none
module yaz0_copier #(
	parameter int WINDOW_BYTES = 4096,
	parameter int BYTES_PER_RESULT = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire yaz0_pkg::cmd_t      cmd,
	input  wire logic                cmd_empty,
	output logic                     cmd_rd,
	output yaz0_pkg::out_item_t      res,
	output logic                     empty,
	input  wire logic                pop,
	output logic                     done
);
	localparam int AW = $clog2(WINDOW_BYTES);
	localparam int CW = $clog2(BYTES_PER_RESULT + 1);

	yaz0_pkg::back_state_t st_q, st_n;
	logic [AW-1:0] wp_q;
	logic [8:0]    rem_q;
	logic [AW-1:0] src_q;
	logic [63:0]   acc_q;
	logic [CW-1:0] n_q;
	logic          ovalid_q;
	yaz0_pkg::out_item_t out_q;
	logic          done_q;

	logic          we;
	logic [7:0]    wdata;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;
	logic          put;
	logic          emit_full;
	logic          can_go;

	yaz0_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
		.clk(clk), .we(we), .waddr(wp_q), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign res   = out_q;
	assign empty = !ovalid_q;
	assign done  = done_q;
	// result register must be free, or popped in the same cycle, before anything can be emitted
	assign can_go = !ovalid_q || pop;

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			yaz0_pkg::BK_IDLE:
				if (!cmd_empty && can_go && cmd.kind == yaz0_pkg::CMD_COPY) st_n = yaz0_pkg::BK_READ;
			yaz0_pkg::BK_READ: st_n = yaz0_pkg::BK_WAIT;
			yaz0_pkg::BK_WAIT:
				if (can_go) st_n = (rem_q == 9'd1) ? yaz0_pkg::BK_IDLE : yaz0_pkg::BK_READ;
			default: st_n = yaz0_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		raddr  = src_q;
		wdata  = rdata;
		put    = 1'b0;
		cmd_rd = 1'b0;
		unique case (st_q)
			yaz0_pkg::BK_IDLE:
				if (!cmd_empty && can_go) begin
					if (cmd.kind == yaz0_pkg::CMD_LIT) begin
						put = 1'b1;
						wdata = cmd.lit;
						cmd_rd = 1'b1;
					end else if (cmd.kind == yaz0_pkg::CMD_END) begin
						cmd_rd = 1'b1;
					end
				end
			yaz0_pkg::BK_WAIT:
				if (can_go) begin
					put = 1'b1;
					if (rem_q == 9'd1) cmd_rd = 1'b1;
				end
			default: ;
		endcase
		we = put;
	end

	assign emit_full = put && (n_q == CW'(BYTES_PER_RESULT - 1));

	always_ff @(posedge clk) begin
		if (st_q == yaz0_pkg::BK_IDLE && !cmd_empty && can_go
			&& cmd.kind == yaz0_pkg::CMD_COPY) begin
			src_q <= wp_q - AW'(cmd.offset) - AW'(1);
			rem_q <= cmd.len;
		end else if (st_q == yaz0_pkg::BK_WAIT && can_go) begin
			src_q <= src_q + AW'(1);
			rem_q <= rem_q - 9'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= yaz0_pkg::BK_IDLE;
			wp_q <= '0;
			acc_q <= '0;
			n_q <= '0;
			ovalid_q <= 1'b0;
			out_q <= '0;
			done_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (pop && ovalid_q) ovalid_q <= 1'b0;
			if (put) wp_q <= wp_q + AW'(1);
			if (emit_full) begin
				out_q.out_bytes  <= acc_q | ({56'd0, wdata} << (8 * n_q));
				out_q.out_count  <= 4'(BYTES_PER_RESULT);
				out_q.out_last   <= 1'b0;
				out_q.out_status <= yaz0_pkg::ST_RUN;
				ovalid_q <= 1'b1;
				acc_q <= '0;
				n_q <= '0;
			end else if (put) begin
				acc_q <= acc_q | ({56'd0, wdata} << (8 * n_q));
				n_q <= n_q + CW'(1);
			end
			// end of a command: flush any partial word, with status if stream ends
			if (cmd_rd && !emit_full) begin
				if (cmd.status != yaz0_pkg::ST_RUN || n_q != '0 || put) begin
					out_q.out_bytes  <= put ? (acc_q | ({56'd0, wdata} << (8 * n_q))) : acc_q;
					out_q.out_count  <= 4'(n_q) + (put ? 4'd1 : 4'd0);
					out_q.out_last   <= cmd.status != yaz0_pkg::ST_RUN;
					out_q.out_status <= cmd.status;
					ovalid_q <= 1'b1;
					acc_q <= '0;
					n_q <= '0;
				end
			end else if (cmd_rd && emit_full && cmd.status != yaz0_pkg::ST_RUN) begin
				out_q.out_last   <= 1'b1;
				out_q.out_status <= cmd.status;
			end
			if (cmd_rd && cmd.status != yaz0_pkg::ST_RUN) done_q <= 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !pop |=> $stable(out_q))
		else $error("result changed while waiting");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == yaz0_pkg::BK_READ |=> st_q == yaz0_pkg::BK_WAIT)
		else $error("read not followed by wait");
	assert property (@(posedge clk) disable iff (!arst_n) n_q < CW'(BYTES_PER_RESULT))
		else $error("packer overflow");
endmodule
`default_nettype wire

FILE: rtl/yaz0_stream_decompressor.sv
// yaz0_stream_decompressor: top level, parser front end, command queue, copy engine
// depends on yaz0_pkg, yaz0_parser, yaz0_cmd_fifo, yaz0_copier
`timescale 1ns / 1ps
`default_nettype none
// Yaz0 decoder taking one compressed byte per transfer. The parser handles header,
// group code and the leading bytes of each token; the copy engine writes a literal
// straight from its command, and a back-reference passes through a read state and
// a wait state per copied byte, set by the registered read of the 4096-byte history
// RAM. The parser stalls while the two-entry command queue is full. Output bytes are
// packed into results of up to BYTES_PER_RESULT bytes; the last result of a
// stream carries the status. After the stream ends further input is held off
// (full high) until reset. The history needs no clearing after reset.
module yaz0_stream_decompressor #(
	parameter int WINDOW_BYTES = 4096,
	parameter int BYTES_PER_RESULT = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire yaz0_pkg::in_item_t  in_item,
	output logic                     full,
	output yaz0_pkg::out_item_t      out_item,
	output logic                     empty,
	input  wire logic                pop
);
	logic           cmd_wr, cmd_full, cmd_rd, cmd_empty, done;
	yaz0_pkg::cmd_t cmd_w, cmd_r;

	yaz0_parser u_parser (
		.clk(clk), .arst_n(arst_n), .push(push), .in_item(in_item), .full(full),
		.cmd_wr(cmd_wr), .cmd(cmd_w), .cmd_full(cmd_full), .done(done)
	);

	yaz0_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(cmd_wr), .wdata(cmd_w), .full(cmd_full),
		.rd(cmd_rd), .rdata(cmd_r), .empty(cmd_empty)
	);

	yaz0_copier #(.WINDOW_BYTES(WINDOW_BYTES), .BYTES_PER_RESULT(BYTES_PER_RESULT)) u_copier (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_r), .cmd_empty(cmd_empty), .cmd_rd(cmd_rd),
		.res(out_item), .empty(empty), .pop(pop), .done(done)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.out_last |-> out_item.out_status != yaz0_pkg::ST_RUN)
		else $error("final result without status");
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_item.out_count <= 4'(BYTES_PER_RESULT))
		else $error("result count too large");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> full)
		else $error("input taken after stream end");
endmodule
`default_nettype wire

FILE: sim/yaz0_stream_decompressor_tb.sv
// yaz0_stream_decompressor_tb: self-checking bench for the yaz0 stream decompressor
// builds one random compressed stream, predicts the decoded results and checks them
// depends on yaz0_pkg and yaz0_stream_decompressor
`timescale 1ns / 1ps
module yaz0_stream_decompressor_tb;

	localparam int WINDOW = 4096;

	typedef enum int {END_OK, END_TRUNC, END_DIST} stream_end_t;

	logic clk;
	logic arst_n;
	logic push;
	yaz0_pkg::in_item_t in_item;
	logic full;
	yaz0_pkg::out_item_t out_item;
	logic empty;
	logic pop;

	yaz0_stream_decompressor dut (
		.clk(clk), .arst_n(arst_n), .push(push), .in_item(in_item), .full(full),
		.out_item(out_item), .empty(empty), .pop(pop)
	);

	// decoder shadow state
	logic [7:0]  hist [WINDOW];
	int          hdr_seen;
	logic [31:0] target_size;
	logic [31:0] produced;
	logic [7:0]  code_byte;
	int          code_bits;
	int          tok_phase;
	logic [7:0]  ref_first;
	logic [7:0]  ref_second;
	bit          stream_done;
	logic [63:0] word_acc;
	int          word_n;

	yaz0_pkg::in_item_t  pending_bytes[$];
	yaz0_pkg::out_item_t expected_words[$];
	int        gen_count;
	int        sent;
	int        errors;
	bit        acc_in;
	int        tx_idle;
	int        rx_idle;
	int        hold_left;
	bit        hold_done;

	function automatic void flush_word(input bit last, input logic [2:0] st);
		yaz0_pkg::out_item_t w;
		w.out_bytes = word_acc;
		w.out_count = 4'(word_n);
		w.out_last = last;
		w.out_status = st;
		expected_words.push_back(w);
		word_acc = '0;
		word_n = 0;
	endfunction

	function automatic void emit_byte(input logic [7:0] b);
		hist[produced[11:0]] = b;
		produced++;
		word_acc |= 64'(b) << (8 * word_n);
		word_n++;
		if (word_n == 8)
			flush_word(1'b0, yaz0_pkg::ST_RUN);
	endfunction

	function automatic void next_token();
		code_byte = code_byte << 1;
		if (code_bits > 0)
			code_bits--;
		tok_phase = 0;
	endfunction

	function automatic bit copy_back(input int len);
		int offset;
		offset = {ref_first[3:0], ref_second} + 1;
		if (offset > produced)
			return 0;
		for (int i = 0; i < len && produced < target_size; i++)
			emit_byte(hist[12'(produced - offset)]);
		next_token();
		return 1;
	endfunction

	// expected results of one accepted byte
	task automatic decode_byte(input yaz0_pkg::in_item_t it);
		logic [2:0] st;
		logic [7:0] magic [4];
		int words_before;
		magic = '{8'h59, 8'h61, 8'h7A, 8'h30};
		st = yaz0_pkg::ST_RUN;
		words_before = expected_words.size();
		if (!stream_done) begin
			word_acc = '0;
			word_n = 0;
			if (hdr_seen < yaz0_pkg::HEADER_BYTES) begin
				if (hdr_seen < 4 && it.in_byte != magic[hdr_seen])
					st = yaz0_pkg::ST_BAD_MAGIC;
				else if (hdr_seen >= 4 && hdr_seen < 8)
					target_size = {target_size[23:0], it.in_byte};
				if (st == yaz0_pkg::ST_RUN) begin
					hdr_seen++;
					if (hdr_seen == yaz0_pkg::HEADER_BYTES && target_size == 0)
						st = yaz0_pkg::ST_OK;
				end
			end else if (tok_phase == 0 && code_bits == 0) begin
				code_byte = it.in_byte;
				code_bits = 8;
			end else if (tok_phase == 0) begin
				if (code_byte[7]) begin
					emit_byte(it.in_byte);
					next_token();
				end else begin
					ref_first = it.in_byte;
					tok_phase = 1;
				end
			end else if (tok_phase == 1) begin
				ref_second = it.in_byte;
				if (ref_first[7:4] != 0) begin
					if (!copy_back(ref_first[7:4] + 2))
						st = yaz0_pkg::ST_DIST;
				end else
					tok_phase = 2;
			end else if (!copy_back(it.in_byte + 18))
				st = yaz0_pkg::ST_DIST;
			if (st == yaz0_pkg::ST_RUN && hdr_seen >= yaz0_pkg::HEADER_BYTES
				&& produced >= target_size)
				st = yaz0_pkg::ST_OK;
			if (st == yaz0_pkg::ST_RUN && it.in_last)
				st = yaz0_pkg::ST_TRUNC;
			if (st != yaz0_pkg::ST_RUN) begin
				stream_done = 1;
				if (word_n > 0 || expected_words.size() == words_before)
					flush_word(1'b1, st);
				else begin
					expected_words[$].out_last = 1'b1;
					expected_words[$].out_status = st;
				end
			end else if (word_n > 0)
				flush_word(1'b0, yaz0_pkg::ST_RUN);
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input bit last);
		yaz0_pkg::in_item_t it;
		it.in_byte = b;
		it.in_last = last;
		pending_bytes.push_back(it);
		decode_byte(it);
		gen_count++;
	endtask

	task automatic add_group(input logic [7:0] code);
		int maxd;
		int offset;
		add_byte(code, 1'b0);
		for (int k = 7; k >= 0 && !stream_done; k--) begin
			if (code[k]) begin
				add_byte(8'($urandom), produced + 1 == target_size);
			end else begin
				maxd = produced < WINDOW ? produced : WINDOW;
				offset = ($urandom_range(0, 1) == 0) ? $urandom_range(1, maxd < 16 ? maxd : 16)
				                                     : $urandom_range(1, maxd);
				offset = offset - 1;
				if ($urandom_range(0, 99) < 85) begin
					add_byte({4'($urandom_range(1, 15)), 4'(offset >> 8)}, 1'b0);
					if (!stream_done)
						add_byte(8'(offset), 1'b0);
				end else begin
					add_byte({4'h0, 4'(offset >> 8)}, 1'b0);
					if (!stream_done)
						add_byte(8'(offset), 1'b0);
					if (!stream_done)
						add_byte(($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 20))
						                                      : 8'($urandom), 1'b0);
				end
			end
		end
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("yaz0_stream_decompressor verification failed");
		$finish;
	end

	// monitor: record input transfers, check results
	always @(posedge clk) begin
		acc_in <= push && !full;
		if (pop && !empty) begin
			if (expected_words.size() == 0) begin
				$display("%0t unexpected result: got %h/%0d/%0b/%0d", $time,
				         out_item.out_bytes, out_item.out_count, out_item.out_last,
				         out_item.out_status);
				errors++;
			end else begin
				if (out_item !== expected_words[0]) begin
					$display("%0t mismatch: expected %h/%0d/%0b/%0d got %h/%0d/%0b/%0d",
					         $time, expected_words[0].out_bytes, expected_words[0].out_count,
					         expected_words[0].out_last, expected_words[0].out_status,
					         out_item.out_bytes, out_item.out_count, out_item.out_last,
					         out_item.out_status);
					errors++;
				end
				void'(expected_words.pop_front());
			end
		end
	end

	// sender, changes on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (acc_in && push) begin
				void'(pending_bytes.pop_front());
				sent++;
			end
			tx_idle = sent < 160 ? 25 : (sent < 320 ? 74 : 0);
			rx_idle = sent < 160 ? 74 : (sent < 320 ? 25 : 0);
			if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= tx_idle) begin
				push <= 1'b1;
				in_item <= pending_bytes[0];
			end else
				push <= 1'b0;
		end
	end

	// receiver, with one long hold to back the block up
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && sent >= 40) begin
				hold_done = 1;
				hold_left = 800;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else
				pop <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	initial begin
		stream_end_t how;
		logic [31:0] size;
		push = 0;
		pop = 0;
		in_item = '0;
		arst_n = 0;
		errors = 0;
		sent = 0;
		gen_count = 0;
		hold_left = 0;
		hold_done = 0;
		acc_in = 0;
		tx_idle = 25;
		rx_idle = 74;
		hdr_seen = 0;
		target_size = 0;
		produced = 0;
		code_byte = 0;
		code_bits = 0;
		tok_phase = 0;
		ref_first = 0;
		ref_second = 0;
		stream_done = 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: how = END_OK;
			4, 5, 6: how = END_TRUNC;
			default: how = END_DIST;
		endcase
		size = (how == END_OK) ? 32'($urandom_range(2200, 3200)) : 32'hFFFF_FFFF;

		// header
		add_byte(8'h59, 0);
		add_byte(8'h61, 0);
		add_byte(8'h7A, 0);
		add_byte(8'h30, 0);
		for (int i = 3; i >= 0; i--)
			add_byte(size[8*i +: 8], 0);
		for (int i = 0; i < 8; i++)
			add_byte(8'($urandom), 0);

		// directed group: literal extremes, overlapping copies, both match forms
		add_byte(8'hC0, 0);
		add_byte(8'h00, 0);
		add_byte(8'hFF, 0);
		add_byte(8'h10, 0);
		add_byte(8'h00, 0);
		add_byte(8'hF0, 0);
		add_byte(8'h00, 0);
		add_byte(8'h00, 0);
		add_byte(8'h01, 0);
		add_byte(8'hFF, 0);
		add_byte(8'h00, 0);
		add_byte(8'h00, 0);
		add_byte(8'h00, 0);
		add_byte(8'h20, 0);
		add_byte(8'h02, 0);
		add_byte(8'h30, 0);
		add_byte(8'h04, 0);

		while (!stream_done && (how == END_OK || gen_count < 450))
			add_group(8'($urandom));
		if (!stream_done) begin
			if (how == END_DIST && produced < WINDOW) begin
				add_byte(8'h00, 0);
				add_byte(8'h1F, 0);
				add_byte(8'hFF, 0);
			end else
				add_byte(8'($urandom), 1);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		while (pending_bytes.size() > 0 || expected_words.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("yaz0_stream_decompressor verification clean");
		else
			$display("yaz0_stream_decompressor verification failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/yaz0_pkg.sv
rtl/yaz0_ram.sv
rtl/yaz0_cmd_fifo.sv
rtl/yaz0_parser.sv
rtl/yaz0_copier.sv
rtl/yaz0_stream_decompressor.sv
sim/yaz0_stream_decompressor_tb.sv
